// File: rtl/core/sect_pkg.sv
// ----------------------------------------------------------------------------
// sect_pkg
// Shared types and constants for the slab entry cache table: table depth,
// derived counter widths, operation codes and the request/response payloads.
// ----------------------------------------------------------------------------
package sect_pkg;

  // Number of table entries (1 to 16).
  localparam int TABLE_DEPTH = 4;

  // Field widths fixed by the interface.
  localparam int FUNC_W     = 3;
  localparam int HANDLE_W   = 48;
  localparam int BIT_IDX_W  = 16;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 5;

  // Internal widths derived from the depth.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Operation codes; codes above FUNC_PURGE do nothing.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND      = 3'd0,
    FUNC_DELETE      = 3'd1,
    FUNC_FIND_DIRTY  = 3'd2,
    FUNC_FIND_USABLE = 3'd3,
    FUNC_PURGE       = 3'd4
  } func_e;

  // Request transaction payload.
  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [HANDLE_W-1:0]  slab_handle;
    logic [BIT_IDX_W-1:0] bit_index;
    logic                 dirty_flag;
    logic [POS_W-1:0]     entry_position;
  } req_t;

  // Response transaction payload.
  typedef struct packed {
    logic                 ok;
    logic [POS_W-1:0]     found_position;
    logic [BIT_IDX_W-1:0] found_bit_index;
    logic [HANDLE_W-1:0]  found_handle;
    logic [COUNT_W-1:0]   entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and rewind the scan pointers
    logic step;    // perform one scan step of the current operation
    logic finish;  // copy the result into the response register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;    // the current step is the last one of the operation
  } dp_sts_t;

endpackage

// File: rtl/core/sect_ctrl.sv
// ----------------------------------------------------------------------------
// sect_ctrl
// Controller for the slab entry cache table: sequences accept, scan steps
// and response hand-off, and owns the response valid flag.
// ----------------------------------------------------------------------------
module sect_ctrl
  import sect_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   slot_free;

  // The response register can take a new result when empty or being drained.
  assign slot_free = !rsp_valid || !rsp_stall;

  // Requests are only taken while no operation is in flight.
  assign req_stall = (state != ST_IDLE);

  // Command decode and next state.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.finish     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: rtl/core/sect_dp.sv
// ----------------------------------------------------------------------------
// sect_dp
// Datapath for the slab entry cache table: entry storage, scan pointers,
// match logic, compaction writes and the response register.
// ----------------------------------------------------------------------------
module sect_dp
  import sect_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  output rsp_t    rsp,
  input  dp_cmd_t cmd,
  output dp_sts_t sts
);

  // Entry storage.
  logic [HANDLE_W-1:0]  ent_handle [TABLE_DEPTH];
  logic [BIT_IDX_W-1:0] ent_bit    [TABLE_DEPTH];
  logic                 ent_dirty  [TABLE_DEPTH];

  // Captured request.
  logic [FUNC_W-1:0]    op_func;
  logic [HANDLE_W-1:0]  op_handle;
  logic [BIT_IDX_W-1:0] op_bit;
  logic                 op_flag;
  logic [POS_W-1:0]     op_pos;

  // Scan state and table fill level.
  logic [CNT_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     wr_ptr;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  // Result under construction.
  logic                 res_ok;
  logic [POS_W-1:0]     res_pos;
  logic [BIT_IDX_W-1:0] res_bit;
  logic [HANDLE_W-1:0]  res_handle;

  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     tail_idx;
  logic [HANDLE_W-1:0]  rd_handle;
  logic [BIT_IDX_W-1:0] rd_bit;
  logic                 rd_dirty;
  logic                 in_range;
  logic                 is_find;
  logic                 is_compact;
  logic                 hit;
  logic                 drop;
  logic                 has_room;

  // One entry is read per cycle at the scan pointer.
  assign rd_idx    = rd_ptr[IDX_W-1:0];
  assign wr_idx    = wr_ptr[IDX_W-1:0];
  assign tail_idx  = count[IDX_W-1:0];
  assign rd_handle = ent_handle[rd_idx];
  assign rd_bit    = ent_bit[rd_idx];
  assign rd_dirty  = ent_dirty[rd_idx];

  assign in_range   = (rd_ptr < count);
  assign has_room   = (count < CNT_W'(TABLE_DEPTH));
  assign is_find    = (op_func == FUNC_FIND_DIRTY) || (op_func == FUNC_FIND_USABLE);
  assign is_compact = (op_func == FUNC_DELETE) || (op_func == FUNC_PURGE);

  // Match for the find operations; find-usable without the clean
  // requirement accepts any entry.
  assign hit = (op_func == FUNC_FIND_DIRTY) ? (rd_dirty == op_flag)
                                            : (!op_flag || !rd_dirty);

  // Entry removed by the compaction pass.
  assign drop = (op_func == FUNC_DELETE) ? (POS_W'(rd_ptr) == op_pos)
                                         : (rd_handle == op_handle);

  // The operation ends after this step.
  assign sts.done = !in_range || !(is_find || is_compact) || (is_find && hit);

  // Fill level update.
  always_comb begin
    count_next = count;
    if (cmd.step) begin
      case (op_func)
        FUNC_APPEND: begin
          if (has_room) begin
            count_next = count + CNT_W'(1);
          end
        end
        FUNC_DELETE, FUNC_PURGE: begin
          if (!in_range) begin
            count_next = wr_ptr;
          end
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Request capture, scan steps and table writes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func    <= req.func;
      op_handle  <= req.slab_handle;
      op_bit     <= req.bit_index;
      op_flag    <= req.dirty_flag;
      op_pos     <= req.entry_position;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      res_ok     <= 1'b0;
      res_pos    <= '0;
      res_bit    <= '0;
      res_handle <= '0;
    end else if (cmd.step) begin
      case (op_func)
        FUNC_APPEND: begin
          if (has_room) begin
            ent_handle[tail_idx] <= op_handle;
            ent_bit[tail_idx]    <= op_bit;
            ent_dirty[tail_idx]  <= op_flag;
            res_ok               <= 1'b1;
          end
        end
        FUNC_DELETE, FUNC_PURGE: begin
          // Kept entries slide down to the write pointer.
          if (in_range) begin
            if (drop) begin
              res_ok <= 1'b1;
            end else begin
              if (wr_ptr != rd_ptr) begin
                ent_handle[wr_idx] <= rd_handle;
                ent_bit[wr_idx]    <= rd_bit;
                ent_dirty[wr_idx]  <= rd_dirty;
              end
              wr_ptr <= wr_ptr + CNT_W'(1);
            end
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
        end
        FUNC_FIND_DIRTY, FUNC_FIND_USABLE: begin
          if (in_range) begin
            if (hit) begin
              res_ok     <= 1'b1;
              res_pos    <= POS_W'(rd_idx);
              res_bit    <= rd_bit;
              res_handle <= rd_handle;
            end else begin
              rd_ptr <= rd_ptr + CNT_W'(1);
            end
          end
        end
        default: begin
          res_ok <= 1'b0;
        end
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.ok              <= res_ok;
      rsp.found_position  <= res_pos;
      rsp.found_bit_index <= res_bit;
      rsp.found_handle    <= res_handle;
      rsp.entry_count     <= COUNT_W'(count);
    end
  end

endmodule

// File: rtl/core/slab_entry_cache_table_unit.sv
// ----------------------------------------------------------------------------
// slab_entry_cache_table_unit
// Ordered table of slab entries with append, delete-at, find and purge.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req, req_valid, req_stall) carries one operation per
//   transaction; the response channel (rsp, rsp_valid, rsp_stall) returns
//   exactly one result per request, in order.
//   A request is taken only while no operation is in flight. The operation
//   then scans the table at the single read port, one table entry per cycle:
//   append writes at the tail when there is room, unknown codes do nothing,
//   a find stops at the first hit, and a find miss, delete-at and purge visit
//   every entry. A finish step then moves the result into the response
//   register, and the next request is taken once the block is idle again.
//   When the receiver stalls, the response register holds its result while
//   the next request is still taken and processed; that result waits in the
//   finish state until the register frees.
//   Reset empties the table (entry count zero) and drops any response.
// ----------------------------------------------------------------------------
module slab_entry_cache_table_unit
  import sect_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Operation sequencing.
  sect_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Table storage and scan logic.
  sect_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// File: tb/slab_table_checker.sv
// ----------------------------------------------------------------------------
// slab_table_checker
// Watches both channels of the slab entry cache table. Every accepted request
// is run through a local model of the table, and the predicted response is
// queued. Every accepted response is compared field by field with the oldest
// prediction. The failure count and the number of outstanding predictions
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module slab_table_checker
  import sect_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   failures,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Local copy of the table contents and its fill level.
  logic [HANDLE_W-1:0]  slot_handle [TABLE_DEPTH];
  logic [BIT_IDX_W-1:0] slot_bit_idx [TABLE_DEPTH];
  logic                 slot_dirty [TABLE_DEPTH];
  int                   live_count;

  // Predicted responses, oldest first.
  rsp_t table_outcomes[$];

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    failures++;
  endtask

  // Removes one entry and closes the gap, keeping the order of the rest.
  function automatic void drop_entry(input int pos);
    for (int k = pos; k + 1 < live_count; k++) begin
      slot_handle[k]  = slot_handle[k + 1];
      slot_bit_idx[k] = slot_bit_idx[k + 1];
      slot_dirty[k]   = slot_dirty[k + 1];
    end
    live_count--;
  endfunction

  // Applies one operation to the local table and returns the response.
  function automatic rsp_t apply_table_op(input req_t op);
    rsp_t r;
    logic hit;
    int   k;
    r = '0;
    case (op.func)
      FUNC_APPEND: begin
        if (live_count < TABLE_DEPTH) begin
          slot_handle[live_count]  = op.slab_handle;
          slot_bit_idx[live_count] = op.bit_index;
          slot_dirty[live_count]   = op.dirty_flag;
          live_count++;
          r.ok = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (int'(op.entry_position) < live_count) begin
          drop_entry(int'(op.entry_position));
          r.ok = 1'b1;
        end
      end
      FUNC_FIND_DIRTY, FUNC_FIND_USABLE: begin
        for (k = 0; k < live_count; k++) begin
          if (op.func == FUNC_FIND_DIRTY) begin
            hit = (slot_dirty[k] == op.dirty_flag);
          end else begin
            hit = !op.dirty_flag || !slot_dirty[k];
          end
          if (hit) begin
            r.ok              = 1'b1;
            r.found_position  = POS_W'(k);
            r.found_bit_index = slot_bit_idx[k];
            r.found_handle    = slot_handle[k];
            break;
          end
        end
      end
      FUNC_PURGE: begin
        k = 0;
        while (k < live_count) begin
          if (slot_handle[k] == op.slab_handle) begin
            drop_entry(k);
            r.ok = 1'b1;
          end else begin
            k++;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(live_count);
    return r;
  endfunction

  // Retire responses against predictions, then predict for new requests.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      live_count = 0;
      table_outcomes.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (table_outcomes.size() == 0) begin
          report_mismatch($sformatf("response transaction with nothing outstanding: %h", rsp));
        end else begin
          want = table_outcomes.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch($sformatf("ok %b, expected %b", rsp.ok, want.ok));
          if (rsp.found_position !== want.found_position)
            report_mismatch($sformatf("found_position %0d, expected %0d",
                                      rsp.found_position, want.found_position));
          if (rsp.found_bit_index !== want.found_bit_index)
            report_mismatch($sformatf("found_bit_index %h, expected %h",
                                      rsp.found_bit_index, want.found_bit_index));
          if (rsp.found_handle !== want.found_handle)
            report_mismatch($sformatf("found_handle %h, expected %h",
                                      rsp.found_handle, want.found_handle));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      rsp.entry_count, want.entry_count));
        end
      end
      if (req_valid && !req_stall) begin
        table_outcomes.push_back(apply_table_op(req));
      end
    end
    pending <= table_outcomes.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the slab entry cache table with a directed opening sequence and then
// with random bursts of operations over a small pool of handles, so that
// purges hit often. The response side stalls in changing patterns.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sect_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1150;
  localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = FUNC_W'(FUNC_PURGE + 1);
  localparam logic [HANDLE_W-1:0] HANDLE_ONES = {HANDLE_W{1'b1}};

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   failures;
  int   pending;

  // Handles reused across operations so that purges find matches.
  logic [HANDLE_W-1:0] handle_pool [4];

  // Receiver stall pattern state.
  int stall_mode;
  int stall_left;

  slab_entry_cache_table_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  slab_table_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stretches of no stalls, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       rsp_stall <= 1'b0;
      1:       rsp_stall <= ($urandom_range(0, 3) == 0);
      default: rsp_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Run ends here if the block stops answering.
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [HANDLE_W-1:0] rand_handle();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic req_t make_op(input logic [FUNC_W-1:0] f,
                                   input logic [HANDLE_W-1:0] h,
                                   input logic [BIT_IDX_W-1:0] b,
                                   input logic d,
                                   input logic [POS_W-1:0] p);
    req_t op;
    op.func           = f;
    op.slab_handle    = h;
    op.bit_index      = b;
    op.dirty_flag     = d;
    op.entry_position = p;
    return op;
  endfunction

  // Random operation; append_pct sets how quickly the table fills.
  function automatic req_t random_op(input int append_pct);
    logic [FUNC_W-1:0]   f;
    logic [HANDLE_W-1:0] h;
    logic [POS_W-1:0]    p;
    int                  pick;
    pick = $urandom_range(0, 99);
    if (pick < append_pct)
      f = FUNC_APPEND;
    else if (pick < append_pct + (100 - append_pct) * 20 / 100)
      f = FUNC_DELETE;
    else if (pick < append_pct + (100 - append_pct) * 45 / 100)
      f = FUNC_FIND_DIRTY;
    else if (pick < append_pct + (100 - append_pct) * 70 / 100)
      f = FUNC_FIND_USABLE;
    else if (pick < 95)
      f = FUNC_PURGE;
    else
      f = FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, 2**FUNC_W - 1));
    h = ($urandom_range(0, 3) == 0) ? rand_handle() : handle_pool[$urandom_range(0, 3)];
    p = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 15))
                                    : POS_W'($urandom_range(0, TABLE_DEPTH));
    return make_op(f, h, 16'($urandom), 1'($urandom_range(0, 1)), p);
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_op(input req_t op);
    req       <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic idle_sender(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits, with a bound, until every predicted response has come back.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 10000);
  endtask

  function automatic void refresh_pool();
    for (int i = 0; i < 4; i++) handle_pool[i] = rand_handle();
    if ($urandom_range(0, 3) == 0) handle_pool[0] = '0;
    if ($urandom_range(0, 3) == 0) handle_pool[1] = HANDLE_ONES;
  endfunction

  // Stimulus: reset, directed sequence, then random bursts.
  initial begin
    int   useful;
    int   next_drain;
    int   burst;
    int   append_pct;
    req_t op;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    refresh_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every lookup and removal on an empty table misses.
    send_op(make_op(FUNC_FIND_DIRTY, '0, '0, 1'b0, '0));
    send_op(make_op(FUNC_FIND_USABLE, '0, '0, 1'b1, '0));
    send_op(make_op(FUNC_DELETE, '0, '0, 1'b0, '0));
    send_op(make_op(FUNC_PURGE, '0, '0, 1'b0, '0));
    // Fill the table with extreme field values, then overflow it.
    send_op(make_op(FUNC_APPEND, '0, '0, 1'b1, '0));
    send_op(make_op(FUNC_APPEND, HANDLE_ONES, 16'hffff, 1'b0, 4'hf));
    send_op(make_op(FUNC_APPEND, '0, 16'h1234, 1'b1, '0));
    send_op(make_op(FUNC_APPEND, 48'h5, 16'h5, 1'b0, '0));
    send_op(make_op(FUNC_APPEND, 48'h9, 16'h9, 1'b1, '0));
    // Finds on a full table, with and without the clean requirement.
    send_op(make_op(FUNC_FIND_DIRTY, '0, '0, 1'b1, '0));
    send_op(make_op(FUNC_FIND_DIRTY, '0, '0, 1'b0, '0));
    send_op(make_op(FUNC_FIND_USABLE, '0, '0, 1'b1, '0));
    send_op(make_op(FUNC_FIND_USABLE, '0, '0, 1'b0, '0));
    // Delete beyond the fill level, then the last entry.
    send_op(make_op(FUNC_DELETE, '0, '0, 1'b0, 4'hf));
    send_op(make_op(FUNC_DELETE, '0, '0, 1'b0, POS_W'(TABLE_DEPTH - 1)));
    // Purge the zero handle, which sits twice, then a handle that is absent.
    send_op(make_op(FUNC_PURGE, '0, '0, 1'b0, '0));
    send_op(make_op(FUNC_PURGE, 48'h7, '0, 1'b0, '0));
    // Unused operation codes change nothing.
    for (int f = FUNC_FIRST_UNUSED; f < 2**FUNC_W; f++) begin
      send_op(make_op(FUNC_W'(f), HANDLE_ONES, 16'hffff, 1'b1, 4'hf));
    end
    send_op(make_op(FUNC_DELETE, '0, '0, 1'b0, '0));
    send_op(make_op(FUNC_FIND_USABLE, '0, '0, 1'b0, '0));
    // Only dirty entries: a usable lookup that requires clean must miss.
    send_op(make_op(FUNC_APPEND, 48'h3, 16'h3, 1'b1, '0));
    send_op(make_op(FUNC_FIND_USABLE, '0, '0, 1'b1, '0));
    send_op(make_op(FUNC_PURGE, 48'h3, '0, 1'b0, '0));

    // Hold off until the directed part has fully drained.
    idle_sender(0);
    wait_for_results();

    useful     = 0;
    next_drain = 300;
    while (useful < RANDOM_ITEMS) begin
      burst      = $urandom_range(1, 24);
      append_pct = $urandom_range(20, 60);
      repeat (burst) begin
        op = random_op(append_pct);
        send_op(op);
        if (op.func <= FUNC_PURGE) useful++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      if (useful >= next_drain) begin
        idle_sender(0);
        wait_for_results();
        next_drain += 300;
      end
      if ($urandom_range(0, 15) == 0) refresh_pool();
    end

    idle_sender(0);
    wait_for_results();
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
